// File: src/psq_pkg.sv
// Shared operation codes and controller command type for the priority sorted task queue.
package psq_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic signed [7:0] REALTIME_LEVEL_RESET = 8'sd127;

  typedef struct packed {
    logic capture;
    logic execute;
  } psq_cmd_t;

endpackage

// File: src/psq_ctrl.sv
// Controller state machine that sequences request capture, execution and result handoff.
module psq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output psq_pkg::psq_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.capture    = 1'b0;
    cmd.execute    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.execute    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/psq_datapath.sv
// Datapath holding the sorted entry list, realtime slot, request registers and result registers.
module psq_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  psq_pkg::psq_cmd_t   cmd,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic [1:0]          func,
  input  logic [7:0]          task_id,
  input  logic signed [7:0]   priority_req,
  input  logic [5:0]          index,
  output logic                ok,
  output logic [5:0]          count,
  output logic                entry_valid,
  output logic [7:0]          entry_id,
  output logic signed [7:0]   entry_priority,
  output logic                realtime_valid,
  output logic [7:0]          realtime_id
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [1:0]        func_q;
  logic [7:0]        id_q;
  logic signed [7:0] prio_q;
  logic [5:0]        index_q;

  logic signed [7:0] realtime_level;
  logic              rt_held;
  logic [7:0]        rt_task;
  logic [CW-1:0]     cnt;

  logic [7:0]        ids [QUEUE_DEPTH];
  logic signed [7:0] prs [QUEUE_DEPTH];
  logic [7:0]        ids_next [QUEUE_DEPTH];
  logic signed [7:0] prs_next [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] after;
  logic [QUEUE_DEPTH-1:0] past;
  logic [IW-1:0]          match_pos;
  logic                   found;
  logic                   full;
  logic                   is_rt;
  logic                   add_ok;
  logic                   do_ins;
  logic                   do_rem;
  logic                   rd_valid;
  logic [IW-1:0]          rd_addr;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CW'(i) < cnt) && (ids[i] == id_q);
      after[i] = !(CW'(i) < cnt) || (prs[i] < prio_q);
    end
    for (int b = 0; b < IW; b++) begin
      match_pos[b] = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (((i >> b) & 1) == 1) begin
          match_pos[b] = match_pos[b] | match[i];
        end
      end
    end
    found = |match;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      past[i] = found && (IW'(i) >= match_pos);
    end
  end

  assign full     = (cnt >= CW'(QUEUE_DEPTH));
  assign is_rt    = (prio_q == realtime_level);
  assign add_ok   = !full && !found && !(is_rt && rt_held);
  assign do_ins   = (func_q == psq_pkg::FUNC_ADD) && add_ok;
  assign do_rem   = (func_q == psq_pkg::FUNC_REMOVE) && found;
  assign rd_valid = ({1'b0, index_q} < 7'(cnt)) && ({1'b0, index_q} < 7'(QUEUE_DEPTH));
  assign rd_addr  = index_q[IW-1:0];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
    logic [7:0]        ins_id;
    logic signed [7:0] ins_pr;
    logic [7:0]        rem_id;
    logic signed [7:0] rem_pr;
    if (g == 0) begin : g_first
      assign ins_id = id_q;
      assign ins_pr = prio_q;
    end else begin : g_rest
      assign ins_id = after[g-1] ? ids[g-1] : id_q;
      assign ins_pr = after[g-1] ? prs[g-1] : prio_q;
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign rem_id = ids[g];
      assign rem_pr = prs[g];
    end else begin : g_inner
      assign rem_id = ids[g+1];
      assign rem_pr = prs[g+1];
    end
    assign ids_next[g] = (do_ins && after[g]) ? ins_id :
                         (do_rem && past[g])  ? rem_id : ids[g];
    assign prs_next[g] = (do_ins && after[g]) ? ins_pr :
                         (do_rem && past[g])  ? rem_pr : prs[g];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= func;
      id_q    <= task_id;
      prio_q  <= priority_req;
      index_q <= index;
    end
    if (cmd.execute) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ids[i] <= ids_next[i];
        prs[i] <= prs_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      realtime_level <= psq_pkg::REALTIME_LEVEL_RESET;
      rt_held        <= 1'b0;
      rt_task        <= 8'd0;
      cnt            <= '0;
    end else begin
      if (cfg_we) begin
        realtime_level <= cfg_wdata;
      end
      if (cmd.execute) begin
        case (func_q)
          psq_pkg::FUNC_ADD: begin
            if (add_ok) begin
              cnt <= cnt + CW'(1);
              if (is_rt) begin
                rt_held <= 1'b1;
                rt_task <= id_q;
              end
            end
          end
          psq_pkg::FUNC_REMOVE: begin
            if (rt_held && (rt_task == id_q)) begin
              rt_held <= 1'b0;
              rt_task <= 8'd0;
            end
            if (found) begin
              cnt <= cnt - CW'(1);
            end
          end
          psq_pkg::FUNC_CLEAR: begin
            cnt <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result registers are loaded with the post-operation state.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      entry_valid    <= 1'b0;
      entry_id       <= 8'd0;
      entry_priority <= 8'sd0;
      case (func_q)
        psq_pkg::FUNC_ADD: begin
          ok             <= add_ok;
          count          <= 6'(add_ok ? cnt + CW'(1) : cnt);
          realtime_valid <= rt_held || (add_ok && is_rt);
          realtime_id    <= (add_ok && is_rt) ? id_q : (rt_held ? rt_task : 8'd0);
        end
        psq_pkg::FUNC_REMOVE: begin
          ok             <= found;
          count          <= 6'(found ? cnt - CW'(1) : cnt);
          realtime_valid <= rt_held && (rt_task != id_q);
          realtime_id    <= (rt_held && (rt_task != id_q)) ? rt_task : 8'd0;
        end
        psq_pkg::FUNC_CLEAR: begin
          ok             <= 1'b1;
          count          <= 6'd0;
          realtime_valid <= rt_held;
          realtime_id    <= rt_held ? rt_task : 8'd0;
        end
        default: begin
          ok             <= rd_valid;
          count          <= 6'(cnt);
          entry_valid    <= rd_valid;
          entry_id       <= rd_valid ? ids[rd_addr] : 8'd0;
          entry_priority <= rd_valid ? prs[rd_addr] : 8'sd0;
          realtime_valid <= rt_held;
          realtime_id    <= rt_held ? rt_task : 8'd0;
        end
      endcase
    end
  end

endmodule

// File: src/priority_sorted_task_queue_top.sv
// Top level of the priority sorted task queue: controller and datapath.
//
// Each request is captured in the cycle it is accepted and executed once the
// result register is free, when every list entry compares its id and priority in
// parallel and shifts by one place to insert or close a gap. The result waits in
// an output register, and one further request is taken while it waits; that
// request executes as soon as the result register is free. Entries are kept in
// descending priority, equal priorities in arrival order. realtime_level may be
// written only while no request is outstanding.
module priority_sorted_task_queue_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [7:0]        task_id,
  input  logic signed [7:0] priority_req,
  input  logic [5:0]        index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [5:0]        count,
  output logic              entry_valid,
  output logic [7:0]        entry_id,
  output logic signed [7:0] entry_priority,
  output logic              realtime_valid,
  output logic [7:0]        realtime_id
);

  psq_pkg::psq_cmd_t cmd;

  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  psq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .func           (func),
    .task_id        (task_id),
    .priority_req   (priority_req),
    .index          (index),
    .ok             (ok),
    .count          (count),
    .entry_valid    (entry_valid),
    .entry_id       (entry_id),
    .entry_priority (entry_priority),
    .realtime_valid (realtime_valid),
    .realtime_id    (realtime_id)
  );

endmodule

// File: src/psq_checker.sv
// Port-level checker for the priority sorted task queue and its bind statement.
module psq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              ok,
  input logic [5:0]        count,
  input logic              entry_valid,
  input logic [7:0]        entry_id,
  input logic signed [7:0] entry_priority,
  input logic              realtime_valid,
  input logic [7:0]        realtime_id
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Queue took a request while the previous one was executing.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(count)))
    else $error("Stalled result changed before it was taken.");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |-> ok)
    else $error("Valid entry read reported without ok.");

  a_invalid_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !entry_valid) |-> (entry_id == 8'd0 && entry_priority == 8'sd0))
    else $error("Invalid entry read returned nonzero data.");

  a_realtime_id_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !realtime_valid) |-> (realtime_id == 8'd0))
    else $error("Realtime id is nonzero while no realtime task is held.");

endmodule

bind priority_sorted_task_queue_top psq_checker u_psq_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .ok             (ok),
  .count          (count),
  .entry_valid    (entry_valid),
  .entry_id       (entry_id),
  .entry_priority (entry_priority),
  .realtime_valid (realtime_valid),
  .realtime_id    (realtime_id)
);

// File: test/priority_sorted_task_queue_top_test.sv
// Self-checking testbench for the priority sorted task queue with random traffic and stalls.
`timescale 1ns / 100ps

module priority_sorted_task_queue_top_test;

  localparam int QUEUE_DEPTH = 32;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        task_id;
    logic signed [7:0] prio;
    logic [5:0]        index;
  } task_request_t;

  typedef struct packed {
    logic              ok;
    logic [5:0]        count;
    logic              entry_valid;
    logic [7:0]        entry_id;
    logic signed [7:0] entry_priority;
    logic              realtime_valid;
    logic [7:0]        realtime_id;
  } queue_status_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = 8'd0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        func = psq_pkg::FUNC_READ;
  logic [7:0]        task_id = 8'd0;
  logic signed [7:0] priority_req = 8'sd0;
  logic [5:0]        index = 6'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              ok;
  logic [5:0]        count;
  logic              entry_valid;
  logic [7:0]        entry_id;
  logic signed [7:0] entry_priority;
  logic              realtime_valid;
  logic [7:0]        realtime_id;

  task_request_t     pending_requests[$];
  queue_status_t     expected_status[$];
  int                requests_queued = 0;
  int                statuses_checked = 0;
  int                errors = 0;
  bit                no_stall = 1'b0;

  // Shadow copy of the sorted list and the realtime slot.
  logic [7:0]        shadow_id[QUEUE_DEPTH];
  logic signed [7:0] shadow_prio[QUEUE_DEPTH];
  int                shadow_len = 0;
  bit                shadow_rt_held = 1'b0;
  logic [7:0]        shadow_rt_task = 8'd0;
  logic signed [7:0] shadow_rt_level = psq_pkg::REALTIME_LEVEL_RESET;

  int n_adds_taken = 0;
  int n_full_refused = 0;
  int n_dup_refused = 0;
  int n_rt_refused = 0;
  int n_rt_absent_removes = 0;
  int n_reads_valid = 0;
  int n_reads_invalid = 0;

  priority_sorted_task_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .task_id       (task_id),
    .priority_req  (priority_req),
    .index         (index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .count         (count),
    .entry_valid   (entry_valid),
    .entry_id      (entry_id),
    .entry_priority(entry_priority),
    .realtime_valid(realtime_valid),
    .realtime_id   (realtime_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit stall_now();
    return !no_stall && ($urandom_range(0, 99) < 34);
  endfunction

  function automatic int shadow_find(logic [7:0] id);
    int pos;
    pos = -1;
    for (int i = shadow_len - 1; i >= 0; i--) begin
      if (shadow_id[i] == id) begin
        pos = i;
      end
    end
    return pos;
  endfunction

  function automatic queue_status_t apply_request(task_request_t req);
    queue_status_t st;
    int pos;
    bit found;
    st = '0;
    case (req.func)
      psq_pkg::FUNC_ADD: begin
        if (shadow_len >= QUEUE_DEPTH) begin
          n_full_refused++;
        end else if (shadow_find(req.task_id) >= 0) begin
          n_dup_refused++;
        end else if ($signed(req.prio) == shadow_rt_level && shadow_rt_held) begin
          n_rt_refused++;
        end else begin
          if ($signed(req.prio) == shadow_rt_level) begin
            shadow_rt_held = 1'b1;
            shadow_rt_task = req.task_id;
          end
          pos = shadow_len;
          found = 1'b0;
          for (int i = 0; i < shadow_len; i++) begin
            if (!found && $signed(shadow_prio[i]) < $signed(req.prio)) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (int i = shadow_len; i > pos; i--) begin
            shadow_id[i] = shadow_id[i - 1];
            shadow_prio[i] = shadow_prio[i - 1];
          end
          shadow_id[pos] = req.task_id;
          shadow_prio[pos] = req.prio;
          shadow_len++;
          st.ok = 1'b1;
          n_adds_taken++;
        end
      end
      psq_pkg::FUNC_REMOVE: begin
        pos = shadow_find(req.task_id);
        if (shadow_rt_held && shadow_rt_task == req.task_id) begin
          shadow_rt_held = 1'b0;
          shadow_rt_task = 8'd0;
          if (pos < 0) begin
            n_rt_absent_removes++;
          end
        end
        if (pos >= 0) begin
          for (int i = pos; i + 1 < shadow_len; i++) begin
            shadow_id[i] = shadow_id[i + 1];
            shadow_prio[i] = shadow_prio[i + 1];
          end
          shadow_len--;
          st.ok = 1'b1;
        end
      end
      psq_pkg::FUNC_CLEAR: begin
        shadow_len = 0;
        st.ok = 1'b1;
      end
      default: begin
        if (req.index < shadow_len) begin
          st.entry_valid = 1'b1;
          st.entry_id = shadow_id[req.index];
          st.entry_priority = shadow_prio[req.index];
          n_reads_valid++;
        end else begin
          n_reads_invalid++;
        end
        st.ok = st.entry_valid;
      end
    endcase
    st.count = shadow_len[5:0];
    st.realtime_valid = shadow_rt_held;
    st.realtime_id = shadow_rt_held ? shadow_rt_task : 8'd0;
    return st;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Driver: predicts each accepted request and presents the next pending one.
  always @(posedge clk) begin
    task_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req.func = func;
        req.task_id = task_id;
        req.prio = priority_req;
        req.index = index;
        expected_status.push_back(apply_request(req));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && !stall_now()) begin
          req = pending_requests.pop_front();
          func <= req.func;
          task_id <= req.task_id;
          priority_req <= req.prio;
          index <= req.index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted status with the oldest prediction.
  always @(posedge clk) begin
    queue_status_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t: unexpected status, expected none, got ok=%0d count=%0d",
                   $time, ok, count);
        end else begin
          want = expected_status.pop_front();
          check_field("ok", want.ok, ok);
          check_field("count", want.count, count);
          check_field("entry_valid", want.entry_valid, entry_valid);
          check_field("entry_id", want.entry_id, entry_id);
          check_field("entry_priority", want.entry_priority, entry_priority);
          check_field("realtime_valid", want.realtime_valid, realtime_valid);
          check_field("realtime_id", want.realtime_id, realtime_id);
        end
        statuses_checked++;
      end
      out_ready <= !stall_now();
    end
  end

  task automatic push_request(logic [1:0] f, logic [7:0] id, logic signed [7:0] p,
                              logic [5:0] idx);
    task_request_t req;
    req.func = f;
    req.task_id = id;
    req.prio = p;
    req.index = idx;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  task automatic wait_drained();
    while (statuses_checked != requests_queued) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_level(logic signed [7:0] level);
    wait_drained();
    cfg_wdata <= level;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_rt_level = level;
    @(posedge clk);
  endtask

  task automatic queue_random_phase(int n);
    int pick;
    logic [1:0] f;
    logic [7:0] id;
    logic signed [7:0] p;
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int k = 0; k < 36; k++) begin
      push_request(psq_pkg::FUNC_ADD, base + 8'(k), 8'($urandom_range(0, 255)),
                   6'($urandom_range(0, 63)));
    end
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        f = psq_pkg::FUNC_ADD;
      end else if (pick < 66) begin
        f = psq_pkg::FUNC_REMOVE;
      end else if (pick < 98) begin
        f = psq_pkg::FUNC_READ;
      end else begin
        f = psq_pkg::FUNC_CLEAR;
      end
      if ($urandom_range(0, 3) == 0) begin
        id = 8'($urandom_range(0, 255));
      end else begin
        id = 8'($urandom_range(0, 47));
      end
      case ($urandom_range(0, 4))
        0: p = shadow_rt_level;
        1: p = 8'($urandom_range(0, 2)) - 8'sd1;
        2: p = ($urandom_range(0, 1) == 0) ? -8'sd128 : 8'sd127;
        default: p = 8'($urandom_range(0, 255));
      endcase
      push_request(f, id, p, ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                         : 6'($urandom_range(0, 33)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset realtime level.
    push_request(psq_pkg::FUNC_READ, 8'd0, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_READ, 8'd255, -8'sd1, 6'd63);
    push_request(psq_pkg::FUNC_ADD, 8'd0, -8'sd128, 6'd0);
    push_request(psq_pkg::FUNC_ADD, 8'd255, 8'sd127, 6'd63);
    push_request(psq_pkg::FUNC_ADD, 8'd5, 8'sd127, 6'd0);
    push_request(psq_pkg::FUNC_ADD, 8'd0, 8'sd3, 6'd0);
    push_request(psq_pkg::FUNC_ADD, 8'd7, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_ADD, 8'd8, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_ADD, 8'd9, -8'sd128, 6'd0);
    for (int i = 0; i < 6; i++) begin
      push_request(psq_pkg::FUNC_READ, 8'd0, 8'sd0, 6'(i));
    end
    push_request(psq_pkg::FUNC_READ, 8'd0, 8'sd0, 6'd63);
    push_request(psq_pkg::FUNC_REMOVE, 8'd255, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_REMOVE, 8'd200, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_ADD, 8'd41, 8'sd127, 6'd0);
    push_request(psq_pkg::FUNC_CLEAR, 8'd0, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_READ, 8'd0, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_REMOVE, 8'd41, 8'sd0, 6'd0);
    push_request(psq_pkg::FUNC_READ, 8'd0, 8'sd0, 6'd0);
    queue_random_phase(300);

    write_level(-8'sd128);
    queue_random_phase(330);

    write_level(8'sd0);
    no_stall = 1'b1;
    queue_random_phase(380);
    wait_drained();
    no_stall = 1'b0;

    write_level(8'($urandom_range(0, 255)));
    queue_random_phase(330);

    write_level(8'sd127);
    queue_random_phase(330);

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_status.size() != 0) begin
      errors++;
      $display("%0t: %0d statuses expected, got none", $time, expected_status.size());
    end
    $display("Ran %0d requests: %0d adds taken, refusals %0d full, %0d duplicate, %0d realtime.",
             requests_queued, n_adds_taken, n_full_refused, n_dup_refused, n_rt_refused);
    $display("Reads in range %0d, out of range %0d; realtime removes of absent ids %0d.",
             n_reads_valid, n_reads_invalid, n_rt_absent_removes);
    if (errors == 0) begin
      $display("priority_sorted_task_queue_top_test: PASS");
    end else begin
      $display("priority_sorted_task_queue_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d of %0d requests checked.", statuses_checked, requests_queued);
    $display("priority_sorted_task_queue_top_test: FAIL");
    $finish;
  end

endmodule
